>>> rtl/crmp_pkg.sv
// Colour ramp package: field widths, register indexes, stage payload types.
// Used by every module of the two-segment colour ramp unit.
package crmp_pkg;

    localparam int DEF_MAX_ENTRIES = 256;

    localparam int IDX_W  = 9;               // index and count fields
    localparam int CH_W   = 8;               // one colour channel
    localparam int N_CH   = 3;               // red, green, blue
    localparam int COL_W  = N_CH * CH_W;
    localparam int ADDR_W = 3;
    localparam int NUM_W  = CH_W + IDX_W;    // s*(d-i) + e*i stays below 255*512
    localparam int NW     = NUM_W + 1;       // 2*num + d
    localparam int DV_W   = IDX_W + 1;       // 2*d
    localparam int QW     = CH_W;            // quotient bits, one per cell

    localparam logic [IDX_W-1:0] MIN_SINGLE = IDX_W'(2);

    localparam logic MODE_SINGLE = 1'b0;
    localparam logic MODE_TWO    = 1'b1;

    localparam logic [ADDR_W-1:0] REG_MODE         = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] REG_COLOR_START  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] REG_COLOR_MID    = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] REG_COLOR_END    = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] REG_COUNT_FIRST  = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] REG_COUNT_SECOND = ADDR_W'(5);

    typedef struct packed {
        logic [IDX_W-1:0] index;
    } req_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            out_of_range;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [COL_W-1:0]  wdata;
    } cfg_wr_t;

    typedef struct packed {
        logic             mode;
        logic [COL_W-1:0] color_start;
        logic [COL_W-1:0] color_mid;
        logic [COL_W-1:0] color_end;
        logic [IDX_W-1:0] count_first;
        logic [IDX_W-1:0] count_second;
    } cfg_t;

    // Segment picked for one index: end channels, position, divisor n-1.
    typedef struct packed {
        logic                       oor;
        logic [N_CH-1:0][CH_W-1:0]  s;
        logic [N_CH-1:0][CH_W-1:0]  e;
        logic [IDX_W-1:0]           pos;
        logic [IDX_W-1:0]           d;
    } sel_t;

    // Operand travelling down the divider chain.
    typedef struct packed {
        logic                       oor;
        logic [N_CH-1:0][NW-1:0]    rem;
        logic [N_CH-1:0][QW-1:0]    q;
        logic [DV_W-1:0]            dv;
    } div_t;

endpackage

>>> rtl/crmp_chan_if.sv
// Valid/ready channel with a typed payload.
// Standalone; the payload type comes from crmp_pkg at instantiation.
interface crmp_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/two_segment_colour_ramp_unit.sv
// Two-segment colour ramp: returns the gradient colour at a table index.
// Depends on crmp_pkg, crmp_chan_if, crmp_seg, crmp_mul and crmp_div_cell.
//
// Usage:
//   cfg : register writes (addr, wdata); ready is always high. Index 0 mode,
//         1 start colour, 2 mid colour, 3 end colour, 4 first count,
//         5 second count; other indexes are dropped. Write only while idle.
//   req : one table index per transfer.
//   rsp : red, green, blue and out_of_range, one result per index, in order.
// Throughput is one index per clock while rsp is not stalled. Each request
// passes through one segment-select stage, one product stage and a row of
// 8 divider cells, each settling one quotient bit.
// Every stage has its own valid bit and takes new data whenever it is empty
// or its successor moves, so a stalled receiver holds the last result in
// place while the earlier stages keep filling; req.ready falls only when
// every stage holds an item.
// Reset empties the pipeline and loads the register reset values
// (single mode, black to white over 256 entries, mid grey).
module two_segment_colour_ramp_unit
    import crmp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    crmp_chan_if.sink   cfg,
    crmp_chan_if.sink   req,
    crmp_chan_if.source rsp
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    cfg_wr_t wr;

    logic    sel_valid;
    logic    sel_ready;
    sel_t    sel_data;

    logic    c_valid [QW+1];
    logic    c_ready [QW+1];
    div_t    c_data  [QW+1];

    assign wr        = cfg.data;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (wr.addr)
                REG_MODE:         cfg_next.mode         = wr.wdata[0];
                REG_COLOR_START:  cfg_next.color_start  = wr.wdata;
                REG_COLOR_MID:    cfg_next.color_mid    = wr.wdata;
                REG_COLOR_END:    cfg_next.color_end    = wr.wdata;
                REG_COUNT_FIRST:  cfg_next.count_first  = wr.wdata[IDX_W-1:0];
                REG_COUNT_SECOND: cfg_next.count_second = wr.wdata[IDX_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_SINGLE;
            cfg_reg.color_start  <= COL_W'(24'h000000);
            cfg_reg.color_mid    <= COL_W'(24'h808080);
            cfg_reg.color_end    <= COL_W'(24'hFFFFFF);
            cfg_reg.count_first  <= IDX_W'(256);
            cfg_reg.count_second <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    crmp_seg #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_q    (cfg_reg),
        .up_valid (req.valid),
        .up_index (req.data.index),
        .up_ready (req.ready),
        .dn_valid (sel_valid),
        .dn_data  (sel_data),
        .dn_ready (sel_ready)
    );

    crmp_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sel_valid),
        .up_data  (sel_data),
        .up_ready (sel_ready),
        .dn_valid (c_valid[0]),
        .dn_data  (c_data[0]),
        .dn_ready (c_ready[0])
    );

    // Most significant quotient bit first.
    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        crmp_div_cell #(
            .BIT (QW - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (c_valid[k]),
            .up_data  (c_data[k]),
            .up_ready (c_ready[k]),
            .dn_valid (c_valid[k+1]),
            .dn_data  (c_data[k+1]),
            .dn_ready (c_ready[k+1])
        );
    end

    assign rsp.valid             = c_valid[QW];
    assign c_ready[QW]           = rsp.ready;
    assign rsp.data.red          = c_data[QW].q[2];
    assign rsp.data.green        = c_data[QW].q[1];
    assign rsp.data.blue         = c_data[QW].q[0];
    assign rsp.data.out_of_range = c_data[QW].oor;

endmodule

>>> rtl/crmp_seg.sv
// Segment select stage: picks the segment, its end colours and position.
// Depends on crmp_pkg.
module crmp_seg
    import crmp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg_q,
    input  logic             up_valid,
    input  logic [IDX_W-1:0] up_index,
    output logic             up_ready,
    output logic             dn_valid,
    output sel_t             dn_data,
    input  logic             dn_ready
);

    logic             valid_reg;
    logic             valid_next;
    sel_t             data_reg;
    sel_t             data_next;
    logic [IDX_W-1:0] n0s, n1s, n0, n1, nsel;
    logic [IDX_W:0]   total;
    logic             seg2;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        n0s = (32'(cfg_q.count_first) > MAX_ENTRIES) ? IDX_W'(MAX_ENTRIES)
                                                      : cfg_q.count_first;
        n1s = (32'(cfg_q.count_second) > MAX_ENTRIES) ? IDX_W'(MAX_ENTRIES)
                                                       : cfg_q.count_second;
        if (cfg_q.mode == MODE_SINGLE)
        begin
            n0 = (n0s < MIN_SINGLE) ? MIN_SINGLE : n0s;
            n1 = '0;
        end
        else if (n1s == '0)
        begin
            n1 = n0s >> 1;
            n0 = n0s - n1;
        end
        else
        begin
            n0 = n0s;
            n1 = n1s;
        end

        total = {1'b0, n0} + {1'b0, n1};
        seg2  = (cfg_q.mode == MODE_TWO) && (up_index >= n0);
        nsel  = seg2 ? n1 : n0;

        data_next.oor = {1'b0, up_index} >= total;
        data_next.s   = seg2 ? cfg_q.color_mid : cfg_q.color_start;
        data_next.e   = (cfg_q.mode == MODE_SINGLE || seg2) ? cfg_q.color_end
                                                            : cfg_q.color_mid;
        data_next.pos = seg2 ? up_index - n0 : up_index;
        // A one-entry segment divides by one with position zero: start colour.
        data_next.d   = (nsel <= IDX_W'(1)) ? IDX_W'(1) : nsel - IDX_W'(1);

        // Out of range: zero colours fall out of the divider as zero.
        if (data_next.oor)
        begin
            data_next.s   = '0;
            data_next.e   = '0;
            data_next.pos = '0;
            data_next.d   = IDX_W'(1);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/crmp_mul.sv
// Product stage: forms 2*(s*(d-i) + e*i) + d per channel and a shared divisor 2*d.
// Depends on crmp_pkg.
module crmp_mul
    import crmp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  sel_t up_data,
    output logic up_ready,
    output logic dn_valid,
    output div_t dn_data,
    input  logic dn_ready
);

    logic             valid_reg;
    logic             valid_next;
    div_t             data_reg;
    div_t             data_next;
    logic [NUM_W-1:0] num [N_CH];

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next.oor = up_data.oor;
        data_next.dv  = {up_data.d, 1'b0};
        data_next.q   = '0;
        for (int c = 0; c < N_CH; c++)
        begin
            num[c] = NUM_W'(up_data.s[c]) * NUM_W'(up_data.d - up_data.pos)
                   + NUM_W'(up_data.e[c]) * NUM_W'(up_data.pos);
            // Half of the divisor added ahead for round half up.
            data_next.rem[c] = {num[c], 1'b0} + NW'(up_data.d);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/crmp_div_cell.sv
// Divider cell: settles one quotient bit for all three channels.
// Depends on crmp_pkg; a row of QW cells forms the restoring divider.
module crmp_div_cell
    import crmp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  div_t up_data,
    output logic up_ready,
    output logic dn_valid,
    output div_t dn_data,
    input  logic dn_ready
);

    logic          valid_reg;
    logic          valid_next;
    div_t          data_reg;
    div_t          data_next;
    logic [NW-1:0] trial;
    logic          ge [N_CH];

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        trial         = NW'(up_data.dv) << BIT;
        data_next.oor = up_data.oor;
        data_next.dv  = up_data.dv;
        for (int c = 0; c < N_CH; c++)
        begin
            ge[c]            = up_data.rem[c] >= trial;
            data_next.rem[c] = ge[c] ? up_data.rem[c] - trial : up_data.rem[c];
            data_next.q[c]   = {up_data.q[c][QW-2:0], ge[c]};
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/crmp_chk.sv
// Port checker for the colour ramp unit, bound to the top level.
// Depends on crmp_pkg; sees only the top-level ports.
module crmp_chk
    import crmp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // An out-of-range result carries black.
    a_oor_black: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.out_of_range |->
            rsp_data.red == '0 && rsp_data.green == '0 && rsp_data.blue == '0)
        else $error("out_of_range result with nonzero colour");

    // With no result waiting, the pipeline is free to take a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled while output empty");

    // Back-pressure on req only comes from a stalled receiver.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request stalled without output stall");

    // Hold a stalled result.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed or dropped");

endmodule

bind two_segment_colour_ramp_unit crmp_chk u_crmp_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

>>> sim/two_segment_colour_ramp_unit_test.sv
// Regression bench for the two-segment colour ramp unit: directed table, then random phases.
// Depends on crmp_pkg, crmp_chan_if and the two_segment_colour_ramp_unit RTL.
// Every result is checked, in order of request, against a local ramp predictor or a directed expected colour.
module two_segment_colour_ramp_unit_test;
    import crmp_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int RAMP_MAX       = DEF_MAX_ENTRIES;
    localparam int IDLE_PCT       = 8;
    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 40;
    localparam int STEADY_PHASE   = 3;
    localparam int HOLD_PHASE_A   = 6;
    localparam int HOLD_PHASE_B   = 10;

    // Indexes past the register file; writes to them must not land anywhere.
    localparam logic [ADDR_W-1:0] REG_SPARE_LO = ADDR_W'(6);
    localparam logic [ADDR_W-1:0] REG_SPARE_HI = ADDR_W'(7);

    typedef enum logic [1:0] {ROW_WRITE, ROW_LOOKUP, ROW_KNOWN} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [ADDR_W-1:0] addr;
        logic [COL_W-1:0]  wdata;
        logic [IDX_W-1:0]  index;
        rsp_t              want;
    } stim_row_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        rsp_t             color;
    } lookup_t;

    logic clk;
    logic rst_n;

    crmp_chan_if #(.payload_t(cfg_wr_t)) cfg_ch ();
    crmp_chan_if #(.payload_t(req_t))    req_ch ();
    crmp_chan_if #(.payload_t(rsp_t))    rsp_ch ();

    two_segment_colour_ramp_unit #(
        .MAX_ENTRIES(RAMP_MAX)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cfg_t      ramp_cfg;
    lookup_t   pending_colors[$];
    stim_row_t directed_rows[$];

    int  mismatches     = 0;
    int  results_seen   = 0;
    int  past_end       = 0;
    int  lookups_sent   = 0;
    int  reg_writes     = 0;
    int  settings       = 0;
    int  idle_cycles    = 0;
    int  hold_requests  = 0;
    int  holds_done     = 0;
    bit  steady         = 1'b0;

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic void segment_sizes(output int unsigned first_n,
                                          output int unsigned second_n);
        first_n  = (ramp_cfg.count_first > RAMP_MAX) ? RAMP_MAX : ramp_cfg.count_first;
        second_n = (ramp_cfg.count_second > RAMP_MAX) ? RAMP_MAX : ramp_cfg.count_second;
        if (ramp_cfg.mode == MODE_SINGLE) begin
            if (first_n < MIN_SINGLE)
                first_n = MIN_SINGLE;
            second_n = 0;
        end else if (second_n == 0) begin
            second_n = first_n / 2;
            first_n  = first_n - second_n;
        end
    endfunction

    function automatic int unsigned ramp_size();
        int unsigned first_n, second_n;
        segment_sizes(first_n, second_n);
        return first_n + second_n;
    endfunction

    // Exact interpolation, rounded half up.
    function automatic logic [CH_W-1:0] blend_channel(logic [CH_W-1:0] lo, logic [CH_W-1:0] hi,
                                                      int unsigned pos, int unsigned n);
        longint unsigned span, acc;
        if (n <= 1)
            return lo;
        span = n - 1;
        acc  = lo * (span - pos) + hi * pos;
        return CH_W'((2 * acc + span) / (2 * span));
    endfunction

    function automatic rsp_t ramp_color(logic [IDX_W-1:0] index);
        int unsigned      first_n, second_n, pos, n;
        logic [COL_W-1:0] seg_lo, seg_hi;
        rsp_t             c;
        segment_sizes(first_n, second_n);
        c = '0;
        if (index >= first_n + second_n) begin
            c.out_of_range = 1'b1;
            return c;
        end
        if (ramp_cfg.mode == MODE_SINGLE || index < first_n) begin
            seg_lo = ramp_cfg.color_start;
            seg_hi = (ramp_cfg.mode == MODE_SINGLE) ? ramp_cfg.color_end : ramp_cfg.color_mid;
            pos    = index;
            n      = first_n;
        end else begin
            seg_lo = ramp_cfg.color_mid;
            seg_hi = ramp_cfg.color_end;
            pos    = index - first_n;
            n      = second_n;
        end
        c.red   = blend_channel(seg_lo[2*CH_W +: CH_W], seg_hi[2*CH_W +: CH_W], pos, n);
        c.green = blend_channel(seg_lo[CH_W +: CH_W], seg_hi[CH_W +: CH_W], pos, n);
        c.blue  = blend_channel(seg_lo[0 +: CH_W], seg_hi[0 +: CH_W], pos, n);
        return c;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic stim_row_t reg_row(logic [ADDR_W-1:0] addr, logic [COL_W-1:0] value);
        return '{kind: ROW_WRITE, addr: addr, wdata: value, index: '0, want: '0};
    endfunction

    function automatic stim_row_t look_row(logic [IDX_W-1:0] index);
        return '{kind: ROW_LOOKUP, addr: '0, wdata: '0, index: index, want: '0};
    endfunction

    function automatic stim_row_t known_row(logic [IDX_W-1:0] index, logic [COL_W-1:0] rgb,
                                            logic oor);
        rsp_t c;
        c = '{red: rgb[2*CH_W +: CH_W], green: rgb[CH_W +: CH_W], blue: rgb[0 +: CH_W],
              out_of_range: oor};
        return '{kind: ROW_KNOWN, addr: '0, wdata: '0, index: index, want: c};
    endfunction

    function automatic logic [IDX_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return IDX_W'(0);
            1:       return IDX_W'(1);
            2:       return IDX_W'(2);
            3:       return IDX_W'($urandom_range(3, 16));
            4:       return IDX_W'(RAMP_MAX);
            5:       return IDX_W'(511);
            6:       return IDX_W'($urandom_range(RAMP_MAX + 1, 511));
            default: return IDX_W'($urandom_range(1, RAMP_MAX));
        endcase
    endfunction

    function automatic logic [COL_W-1:0] pick_color();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return COL_W'($urandom);
        endcase
    endfunction

    // Mostly inside the table, some right at its end, the rest anywhere.
    function automatic logic [IDX_W-1:0] pick_index(int unsigned size);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (size != 0 && roll < 70)
            return IDX_W'($urandom_range(0, size - 1));
        if (roll < 85)
            return IDX_W'(size - $urandom_range(0, 1));
        return IDX_W'($urandom);
    endfunction

    // Tasks below start and end just after a falling edge, with nothing driven yet in that step.

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [COL_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{addr: addr, wdata: value};
        do @(posedge clk); while (!cfg_ch.ready);
        case (addr)
            REG_MODE:         ramp_cfg.mode         = value[0];
            REG_COLOR_START:  ramp_cfg.color_start  = value;
            REG_COLOR_MID:    ramp_cfg.color_mid    = value;
            REG_COLOR_END:    ramp_cfg.color_end    = value;
            REG_COUNT_FIRST:  ramp_cfg.count_first  = value[IDX_W-1:0];
            REG_COUNT_SECOND: ramp_cfg.count_second = value[IDX_W-1:0];
            default:          ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_index(logic [IDX_W-1:0] index, bit known, rsp_t want);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.data.index <= index;
        do @(posedge clk); while (!req_ch.ready);
        pending_colors.push_back('{index: index, color: known ? want : ramp_color(index)});
        lookups_sent++;
        @(negedge clk);
    endtask

    // Stop offering and hold until every outstanding colour has come back.
    task automatic settle_pipeline();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_colors.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---------------------------------------------------------------- receiver

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_done < hold_requests) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end else begin
                rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------- checker

    always @(posedge clk) begin : check_results
        lookup_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (pending_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result with no lookup outstanding: r=%h g=%h b=%h oor=%b",
                             rsp_ch.data.red, rsp_ch.data.green, rsp_ch.data.blue,
                             rsp_ch.data.out_of_range);
            end else begin
                want = pending_colors.pop_front();
                if (want.color.out_of_range)
                    past_end++;
                if (rsp_ch.data.red != want.color.red
                        || rsp_ch.data.green != want.color.green
                        || rsp_ch.data.blue != want.color.blue
                        || rsp_ch.data.out_of_range != want.color.out_of_range) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("index %0d: expected r=%h g=%h b=%h oor=%b, got r=%h g=%h b=%h oor=%b",
                                 want.index, want.color.red, want.color.green,
                                 want.color.blue, want.color.out_of_range,
                                 rsp_ch.data.red, rsp_ch.data.green, rsp_ch.data.blue,
                                 rsp_ch.data.out_of_range);
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk) begin
        if (rst_n) begin
            if ((cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready)
                    || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("no transfer for %0d cycles, %0d lookups outstanding",
                         idle_cycles, pending_colors.size());
                $display("two_segment_colour_ramp_unit regression: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        bit          in_burst;
        int unsigned size;

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        ramp_cfg     = '{mode: MODE_SINGLE, color_start: 24'h000000, color_mid: 24'h808080,
                         color_end: 24'hFFFFFF, count_first: IDX_W'(256),
                         count_second: IDX_W'(0)};

        directed_rows = '{
            // reset ramp: black to white over 256 entries
            known_row(0, 24'h000000, 1'b0),
            known_row(255, 24'hFFFFFF, 1'b0),
            look_row(128),
            known_row(256, 24'h000000, 1'b1),
            known_row(511, 24'h000000, 1'b1),
            // writes past the register file are dropped
            reg_row(REG_SPARE_LO, 24'hFFFFFF),
            reg_row(REG_SPARE_HI, 24'hABCDEF),
            look_row(1),
            // split of the first count through mid grey
            reg_row(REG_MODE, COL_W'(MODE_TWO)),
            known_row(0, 24'h000000, 1'b0),
            known_row(127, 24'h808080, 1'b0),
            known_row(128, 24'h808080, 1'b0),
            known_row(255, 24'hFFFFFF, 1'b0),
            known_row(256, 24'h000000, 1'b1),
            // falling ramp, both counts oversized and saturated
            reg_row(REG_COLOR_START, 24'hFFFFFF),
            reg_row(REG_COLOR_MID, 24'h00FF00),
            reg_row(REG_COLOR_END, 24'h000000),
            reg_row(REG_COUNT_FIRST, COL_W'(511)),
            reg_row(REG_COUNT_SECOND, COL_W'(300)),
            known_row(0, 24'hFFFFFF, 1'b0),
            known_row(255, 24'h00FF00, 1'b0),
            known_row(256, 24'h00FF00, 1'b0),
            known_row(511, 24'h000000, 1'b0),
            look_row(300),
            // second segment of one entry
            reg_row(REG_COUNT_FIRST, COL_W'(3)),
            reg_row(REG_COUNT_SECOND, COL_W'(1)),
            look_row(1),
            known_row(3, 24'h00FF00, 1'b0),
            known_row(4, 24'h000000, 1'b1),
            // one entry split into a first segment of one and an empty second
            reg_row(REG_COUNT_FIRST, COL_W'(1)),
            reg_row(REG_COUNT_SECOND, COL_W'(0)),
            known_row(0, 24'hFFFFFF, 1'b0),
            known_row(1, 24'h000000, 1'b1),
            // empty table
            reg_row(REG_COUNT_FIRST, COL_W'(0)),
            known_row(0, 24'h000000, 1'b1),
            // single ramp raises a zero count to two
            reg_row(REG_MODE, COL_W'(MODE_SINGLE)),
            known_row(0, 24'hFFFFFF, 1'b0),
            known_row(1, 24'h000000, 1'b0),
            known_row(2, 24'h000000, 1'b1)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        in_burst = 1'b0;
        settings = 1;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                if (in_burst) begin
                    settle_pipeline();
                    settings++;
                end
                in_burst = 1'b0;
                write_reg(directed_rows[i].addr, directed_rows[i].wdata);
            end else begin
                send_index(directed_rows[i].index, directed_rows[i].kind == ROW_KNOWN,
                           directed_rows[i].want);
                in_burst = 1'b1;
            end
        end
        settle_pipeline();

        // Random phases: new settings while idle, then a burst of lookups, then drain.
        for (int phase = 0; phase < PHASES; phase++) begin
            steady = (phase == STEADY_PHASE);
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_MODE, {23'($urandom), 1'($urandom)});
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_COLOR_START, pick_color());
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_COLOR_MID, pick_color());
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_COLOR_END, pick_color());
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_COUNT_FIRST, {15'($urandom), pick_count()});
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_COUNT_SECOND, {15'($urandom), pick_count()});
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, COL_W'($urandom));
            settings++;

            // Receiver stalls while lookups keep coming, so the pipeline fills.
            if (phase == HOLD_PHASE_A || phase == HOLD_PHASE_B)
                hold_requests++;

            size = ramp_size();
            repeat (PHASE_ITEMS)
                send_index(pick_index(size), 1'b0, '0);
            settle_pipeline();
        end
        steady = 1'b0;

        $display("checked %0d of %0d colour lookups (%0d past the table end)",
                 results_seen, lookups_sent, past_end);
        $display("over %0d ramp settings, %0d register writes, %0d mismatches",
                 settings, reg_writes, mismatches);
        if (mismatches == 0 && pending_colors.size() == 0)
            $display("two_segment_colour_ramp_unit regression: pass");
        else
            $display("two_segment_colour_ramp_unit regression: fail");
        $finish;
    end

endmodule
